// ===== hw/rtl/ddtil_pkg.sv =====
`default_nettype none
package ddtil_pkg;
	localparam int TABLE_ENTRIES_DEF = 4096;

	localparam int DEPTH_W = 26;
	localparam int DOSE_W  = 18;
	localparam int CUM_W   = 28;
	localparam int QUERY_W = 27;
	localparam int X_W     = 29;
	localparam int OUT_W   = 29;
	localparam int COUNT_W = 13;
	localparam int CFG_W   = 26;

	localparam int NUM_W = 55;
	localparam int DEN_W = 27;
	localparam int QUO_W = 28;

	localparam logic [1:0] REQ_WRITE    = 2'd0;
	localparam logic [1:0] REQ_POINT    = 2'd1;
	localparam logic [1:0] REQ_INTERVAL = 2'd2;

	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_MAX_DEPTH   = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [DOSE_W-1:0]  dose;
		logic [CUM_W-1:0]   cum;
	} ddtil_entry_t;

	typedef struct packed {
		logic                  start;
		logic                  sel_cum;
		logic signed [X_W-1:0] x;
	} ddtil_ireq_t;

	typedef struct packed {
		logic                    done;
		logic signed [OUT_W-1:0] value;
	} ddtil_ires_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ddtil_req_if.sv =====
`default_nettype none
interface ddtil_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [11:0]        entry_index;
	logic [25:0]        entry_depth;
	logic [17:0]        entry_dose;
	logic [27:0]        entry_cumulative;
	logic signed [26:0] query_depth;
	logic [25:0]        query_width;

	modport source (output valid, req_type, entry_index, entry_depth, entry_dose,
		entry_cumulative, query_depth, query_width, input ready);
	modport sink (input valid, req_type, entry_index, entry_depth, entry_dose,
		entry_cumulative, query_depth, query_width, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ddtil_rsp_if.sv =====
`default_nettype none
interface ddtil_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [28:0] dose_value;

	modport source (output valid, dose_value, input ready);
	modport sink (input valid, dose_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ddtil_ram.sv =====
`default_nettype none
module ddtil_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ddtil_div.sv =====
`default_nettype none
module ddtil_div import ddtil_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] bits_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, bits_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer[NUM_W-1:QUO_W];
			bits_q <= numer[QUO_W-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			bits_q <= {bits_q[QUO_W-2:0], 1'b0};
			quo    <= {quo[QUO_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ddtil_interp.sv =====
`default_nettype none
module ddtil_interp import ddtil_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ddtil_ireq_t                         ireq,
	input  wire logic [$clog2(TABLE_ENTRIES+1)-1:0]  n,
	input  wire ddtil_entry_t                        rd_data,
	output logic      [$clog2(TABLE_ENTRIES)-1:0]    rd_addr,
	output ddtil_ires_t                              ires
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [3:0] {
		I_IDLE, I_CHK, I_CMP, I_LAST, I_RD0, I_RD1, I_MUL, I_DVS, I_DIV
	} istate_t;

	istate_t                 state_q;
	logic signed [X_W-1:0]   x_q;
	logic                    sel_q;
	logic [CW-1:0]           lo_q, hi_q, mid_q;
	logic [CW-1:0]           mid;
	logic [DEPTH_W-1:0]      d0_q;
	logic [CUM_W-1:0]        y0_q;
	logic [DEN_W-1:0]        a_q, den_q;
	logic [QUO_W-1:0]        mag_q;
	logic                    neg_q;
	logic [NUM_W-1:0]        prod_q;
	logic [CUM_W-1:0]        y_rd;
	logic signed [X_W-1:0]   d_rd2;
	logic signed [X_W-1:0]   dy;
	logic signed [X_W-1:0]   a_full;
	logic                    div_done;
	logic [QUO_W-1:0]        quo;
	logic signed [X_W-1:0]   qs;

	assign mid    = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign y_rd   = sel_q ? rd_data.cum : CUM_W'(rd_data.dose);
	assign d_rd2  = $signed({2'b00, rd_data.depth, 1'b0});
	assign dy     = $signed({1'b0, y_rd}) - $signed({1'b0, y0_q});
	assign a_full = x_q - $signed({2'b00, d0_q, 1'b0});
	assign qs     = $signed({1'b0, quo});

	always_comb begin
		rd_addr = '0;
		case (state_q)
			I_CHK: begin
				if (lo_q < hi_q) begin
					rd_addr = AW'(mid);
				end else if (lo_q == n) begin
					rd_addr = AW'(n - 1'b1);
				end else begin
					rd_addr = AW'(lo_q - 1'b1);
				end
			end
			I_RD0: rd_addr = AW'(lo_q);
			default: rd_addr = '0;
		endcase
	end

	ddtil_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == I_DVS),
		.numer (prod_q),
		.den   (den_q),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= I_IDLE;
			ires.done  <= 1'b0;
			ires.value <= '0;
		end else begin
			ires.done <= 1'b0;
			case (state_q)
				I_IDLE: begin
					if (ireq.start) begin
						lo_q    <= '0;
						hi_q    <= n;
						x_q     <= ireq.x;
						sel_q   <= ireq.sel_cum;
						state_q <= I_CHK;
					end
				end
				I_CHK: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= I_CMP;
					end else if (lo_q == '0) begin
						ires.done  <= 1'b1;
						ires.value <= '0;
						state_q    <= I_IDLE;
					end else if (lo_q == n) begin
						state_q <= I_LAST;
					end else begin
						state_q <= I_RD0;
					end
				end
				I_CMP: begin
					if (d_rd2 <= x_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= I_CHK;
				end
				I_LAST: begin
					ires.done  <= 1'b1;
					ires.value <= $signed({1'b0, y_rd});
					state_q    <= I_IDLE;
				end
				I_RD0: begin
					d0_q    <= rd_data.depth;
					y0_q    <= y_rd;
					state_q <= I_RD1;
				end
				I_RD1: begin
					a_q     <= a_full[DEN_W-1:0];
					den_q   <= {DEPTH_W'(rd_data.depth - d0_q), 1'b0};
					neg_q   <= dy[X_W-1];
					mag_q   <= dy[X_W-1] ? QUO_W'(-dy) : QUO_W'(dy);
					state_q <= I_MUL;
				end
				I_MUL: begin
					prod_q  <= NUM_W'(a_q) * NUM_W'(mag_q);
					state_q <= I_DVS;
				end
				I_DVS: state_q <= I_DIV;
				I_DIV: begin
					if (div_done) begin
						ires.done  <= 1'b1;
						ires.value <= $signed({1'b0, y0_q}) + (neg_q ? -qs : qs);
						state_q    <= I_IDLE;
					end
				end
				default: state_q <= I_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/depth_dose_table_interp_lookup_unit.sv =====
`default_nettype none
// Write item or lookup that needs no search: via the output state to the output register.
// Point lookup: binary search over the entries in use, two reads over the single table
// read port, then a 28-step bit-serial divide.
// Interval lookup: two such interpolations in series.
// One item in flight; the next is accepted while the result waits in the output register.
// Reset: entry_count 2, max_depth 0, control idle; table contents undefined until written.
module depth_dose_table_interp_lookup_unit import ddtil_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	ddtil_req_if.sink             req,
	ddtil_rsp_if.source           rsp,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {S_IDLE, S_RUN1, S_RUN2, S_OUT} state_t;

	state_t                  state_q;
	logic [COUNT_W-1:0]      entry_count_q;
	logic [DEPTH_W-1:0]      max_depth_q;
	logic                    point_q;
	logic signed [X_W-1:0]   lower_q;
	logic signed [OUT_W-1:0] up_q;
	logic signed [OUT_W-1:0] res_q;
	logic [31:0]             ec32, n32;
	logic [CW-1:0]           n;
	logic                    accept;
	logic                    out_load;
	logic signed [X_W-1:0]   q2, upper, lower;
	logic                    ram_we;
	ddtil_entry_t            wentry, rentry;
	logic [AW-1:0]           raddr;
	ddtil_ireq_t             ireq;
	ddtil_ires_t             ires;

	assign ec32 = 32'(entry_count_q);
	assign n32  = (ec32 < 32'd2) ? 32'd2 :
		(ec32 > 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES) : ec32;
	assign n    = CW'(n32);

	assign req.ready = state_q == S_IDLE;
	assign accept    = req.valid && req.ready;
	assign out_load  = state_q == S_OUT && (!rsp.valid || rsp.ready);

	assign q2    = {req.query_depth[QUERY_W-1], req.query_depth, 1'b0};
	assign upper = q2 + $signed({3'b000, req.query_width});
	assign lower = q2 - $signed({3'b000, req.query_width});

	assign ram_we = accept && req.req_type == REQ_WRITE
		&& 32'(req.entry_index) < 32'(TABLE_ENTRIES);
	assign wentry = '{depth: req.entry_depth, dose: req.entry_dose,
		cum: req.entry_cumulative};

	always_comb begin
		ireq = '{start: 1'b0, sel_cum: 1'b1, x: lower_q};
		if (accept && req.req_type == REQ_POINT && !req.query_depth[QUERY_W-1]
			&& req.query_depth[DEPTH_W-1:0] <= max_depth_q) begin
			ireq = '{start: 1'b1, sel_cum: 1'b0, x: q2};
		end else if (accept && req.req_type == REQ_INTERVAL && !upper[X_W-1]) begin
			ireq = '{start: 1'b1, sel_cum: 1'b1, x: upper};
		end else if (state_q == S_RUN1 && ires.done && !point_q) begin
			ireq.start = 1'b1;
		end
	end

	ddtil_ram #(
		.WIDTH($bits(ddtil_entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(req.entry_index)),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(rentry)
	);

	ddtil_interp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.ireq   (ireq),
		.n      (n),
		.rd_data(rentry),
		.rd_addr(raddr),
		.ires   (ires)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= COUNT_W'(2);
			max_depth_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT: entry_count_q <= cfg_data[COUNT_W-1:0];
				REG_MAX_DEPTH:   max_depth_q   <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rsp.valid      <= 1'b0;
			rsp.dose_value <= '0;
		end else begin
			if (out_load) begin
				rsp.valid      <= 1'b1;
				rsp.dose_value <= res_q;
			end else if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						point_q <= req.req_type == REQ_POINT;
						lower_q <= lower;
						res_q   <= '0;
						state_q <= ireq.start ? S_RUN1 : S_OUT;
					end
				end
				S_RUN1: begin
					if (ires.done) begin
						if (point_q) begin
							res_q   <= ires.value;
							state_q <= S_OUT;
						end else begin
							up_q    <= ires.value;
							state_q <= S_RUN2;
						end
					end
				end
				S_RUN2: begin
					if (ires.done) begin
						res_q   <= up_q - ires.value;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		ires.done |-> (state_q == S_RUN1 || state_q == S_RUN2))
		else $error("interpolation finished with no lookup running");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_OUT))
		else $error("result offered outside the output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item was dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ireq.start)
		else $error("table write started a lookup");
`endif
endmodule
`default_nettype wire

// ===== dv/depth_dose_table_interp_lookup_unit_tb.sv =====
`default_nettype none
module depth_dose_table_interp_lookup_unit_tb;
	import ddtil_pkg::*;

	localparam int NENT = TABLE_ENTRIES_DEF;
	localparam int DMAX = (1 << DEPTH_W) - 1;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]         req_type;
		logic [11:0]        entry_index;
		logic [25:0]        entry_depth;
		logic [17:0]        entry_dose;
		logic [27:0]        entry_cumulative;
		logic signed [26:0] query_depth;
		logic [25:0]        query_width;
	} lookup_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	ddtil_req_if req();
	ddtil_rsp_if rsp();

	depth_dose_table_interp_lookup_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lookup_item_t pending_items[$];
	logic signed [OUT_W-1:0] expected_doses[$];

	bit [DEPTH_W-1:0] tbl_depth[NENT];
	bit [DOSE_W-1:0]  tbl_dose[NENT];
	bit [CUM_W-1:0]   tbl_cum[NENT];
	bit [COUNT_W-1:0] cur_count = 13'd2;
	bit [DEPTH_W-1:0] cur_max_depth = '0;

	int layout_depth[NENT];
	int snd_idle = 0;
	int rcv_idle = 0;
	bit hold_go = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int mismatches = 0;
	bit accepted = 0;

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.entry_index = '0;
		req.entry_depth = '0;
		req.entry_dose = '0;
		req.entry_cumulative = '0;
		req.query_depth = '0;
		req.query_width = '0;
		rsp.ready = 1'b0;
	end

	function automatic int active_entries();
		if (cur_count < 2) return 2;
		if (cur_count > NENT) return NENT;
		return cur_count;
	endfunction

	function automatic longint interp_at(bit use_cum, longint x, int s);
		int n;
		int k;
		longint lo, hi, y0, y1;
		n = active_entries();
		k = 0;
		while (k < n && (longint'(tbl_depth[k]) << s) <= x) k++;
		if (k == 0) return 0;
		if (k == n) return use_cum ? longint'(tbl_cum[n-1]) : longint'(tbl_dose[n-1]);
		lo = longint'(tbl_depth[k-1]) << s;
		hi = longint'(tbl_depth[k]) << s;
		y0 = use_cum ? longint'(tbl_cum[k-1]) : longint'(tbl_dose[k-1]);
		y1 = use_cum ? longint'(tbl_cum[k]) : longint'(tbl_dose[k]);
		return y0 + ((x - lo) * (y1 - y0)) / (hi - lo);
	endfunction

	function automatic logic signed [OUT_W-1:0] predict_dose(lookup_item_t it);
		longint q, w, r, up, dn;
		q = longint'(it.query_depth);
		w = longint'(it.query_width);
		r = 0;
		case (it.req_type)
			REQ_WRITE: begin
				tbl_depth[it.entry_index] = it.entry_depth;
				tbl_dose[it.entry_index] = it.entry_dose;
				tbl_cum[it.entry_index] = it.entry_cumulative;
			end
			REQ_POINT: begin
				if (q >= 0 && q <= longint'(cur_max_depth)) r = interp_at(0, q, 0);
			end
			REQ_INTERVAL: begin
				up = 2 * q + w;
				dn = 2 * q - w;
				if (up >= 0) r = interp_at(1, up, 1) - interp_at(1, dn, 1);
			end
			default: r = 0;
		endcase
		return r[OUT_W-1:0];
	endfunction

	always @(negedge clk) begin
		lookup_item_t it;
		if (!req.valid || accepted) begin
			if (arst_n && pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
				it = pending_items.pop_front();
				req.req_type <= it.req_type;
				req.entry_index <= it.entry_index;
				req.entry_depth <= it.entry_depth;
				req.entry_dose <= it.entry_dose;
				req.entry_cumulative <= it.entry_cumulative;
				req.query_depth <= it.query_depth;
				req.query_width <= it.query_width;
				req.valid <= 1'b1;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= arst_n && ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		lookup_item_t it;
		logic signed [OUT_W-1:0] want;
		accepted = req.valid && req.ready;
		if (accepted) begin
			it.req_type = req.req_type;
			it.entry_index = req.entry_index;
			it.entry_depth = req.entry_depth;
			it.entry_dose = req.entry_dose;
			it.entry_cumulative = req.entry_cumulative;
			it.query_depth = req.query_depth;
			it.query_width = req.query_width;
			expected_doses.push_back(predict_dose(it));
		end
		if (rsp.valid && rsp.ready) begin
			if (expected_doses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result dose_value=%0d", rsp.dose_value);
			end else begin
				want = expected_doses.pop_front();
				if (rsp.dose_value !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("dose_value expected %0d got %0d", want, rsp.dose_value);
				end
			end
		end
	end

	task automatic write_reg(logic idx, int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		if (idx == REG_ENTRY_COUNT) cur_count = value[COUNT_W-1:0];
		else cur_max_depth = value[DEPTH_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_idle();
		do begin
			wait (pending_items.size() == 0 && expected_doses.size() == 0 && !req.valid);
			repeat (10) @(posedge clk);
		end while (pending_items.size() != 0 || expected_doses.size() != 0 || req.valid);
	endtask

	task automatic push_item(logic [1:0] rt, int idx, int dep, int dose, int cum, int q, int w);
		lookup_item_t it;
		it.req_type = rt;
		it.entry_index = idx[11:0];
		it.entry_depth = dep[25:0];
		it.entry_dose = dose[17:0];
		it.entry_cumulative = cum[27:0];
		it.query_depth = q[26:0];
		it.query_width = w[25:0];
		pending_items.push_back(it);
	endtask

	task automatic load_layout(int n, int span);
		int stepmax;
		stepmax = span / n;
		if (stepmax < 1) stepmax = 1;
		for (int i = 0; i < n; i++) begin
			layout_depth[i] = (i == 0 ? 0 : layout_depth[i-1] + 1) +
				$urandom_range(stepmax - 1);
			push_item(REQ_WRITE, i, layout_depth[i], $urandom_range(18'h3FFFF),
				$urandom_range(28'hFFFFFFF), $urandom, $urandom);
		end
	endtask

	task automatic push_query(int n);
		int lo, hi, q, w, pick;
		lo = layout_depth[0];
		hi = layout_depth[n-1];
		pick = $urandom_range(9);
		if (pick == 0) q = $signed({$urandom} << 5) >>> 5;
		else if (pick < 3) q = layout_depth[$urandom_range(n-1)] + $urandom_range(2) - 1;
		else q = lo - (hi - lo) / 8 + $urandom_range((hi - lo) + (hi - lo) / 4);
		if ($urandom_range(3) == 0) w = $urandom_range(DMAX);
		else w = $urandom_range((hi - lo) / 2 + 1);
		case ($urandom_range(19))
			0: push_item(2'd3, $urandom, $urandom, $urandom, $urandom, q, w);
			1, 2, 3, 4, 5, 6, 7, 8: push_item(REQ_POINT, $urandom, $urandom, $urandom,
				$urandom, q, w);
			default: push_item(REQ_INTERVAL, $urandom, $urandom, $urandom, $urandom, q, w);
		endcase
	endtask

	task automatic push_rewrite(int n);
		int i, lo, hi;
		i = $urandom_range(n - 1);
		lo = (i == 0) ? 0 : layout_depth[i-1] + 1;
		hi = (i == n - 1) ? DMAX : layout_depth[i+1] - 1;
		if (lo <= hi) begin
			layout_depth[i] = lo + $urandom_range(hi - lo);
			push_item(REQ_WRITE, i, layout_depth[i], $urandom_range(18'h3FFFF),
				$urandom_range(28'hFFFFFFF), $urandom, $urandom);
		end
	endtask

	initial begin
		int n, span, lookups, round, nq;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_ENTRY_COUNT, 2);
		write_reg(REG_MAX_DEPTH, DMAX);
		layout_depth[0] = 26'h100000;
		layout_depth[1] = 26'h300000;
		push_item(REQ_WRITE, 0, 26'h100000, 18'h3FFFF, 28'h0000100, 0, 0);
		push_item(REQ_WRITE, 1, 26'h300000, 18'h00000, 28'hFFFFFFF, 0, 0);
		push_item(REQ_WRITE, 4095, DMAX, 18'h3FFFF, 28'hFFFFFFF, 0, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, -(1 << 26), 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 0, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 26'h100000, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 26'h200001, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 26'h300000, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, DMAX, 0);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, 26'h180000, 0);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, 26'h200000, DMAX);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, -(1 << 26), DMAX);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, -5, 9);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, 26'h080000, 26'h180000);
		push_item(REQ_INTERVAL, 0, 0, 0, 0, DMAX, DMAX);
		push_item(2'd3, 4095, DMAX, 18'h3FFFF, 28'hFFFFFFF, -1, DMAX);
		push_item(REQ_POINT, 0, 0, 0, 0, 26'h280000, 0);
		wait_idle();
		write_reg(REG_MAX_DEPTH, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 0, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 1, 0);
		push_item(REQ_POINT, 0, 0, 0, 0, 26'h200000, 0);
		wait_idle();

		snd_idle = 29;
		rcv_idle = 60;
		lookups = 0;
		round = 0;
		while (lookups < 700) begin
			if (lookups > 466) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (lookups > 233) begin
				snd_idle = 60;
				rcv_idle = 29;
			end
			n = ($urandom_range(7) == 0) ? $urandom_range(33, 200) : $urandom_range(2, 32);
			span = ($urandom_range(3) == 0) ? DMAX : $urandom_range(n * 4, DMAX / 4);
			if (n == 2 && $urandom_range(1)) write_reg(REG_ENTRY_COUNT, $urandom_range(1));
			else write_reg(REG_ENTRY_COUNT, n);
			case ($urandom_range(5))
				0: write_reg(REG_MAX_DEPTH, 0);
				1: write_reg(REG_MAX_DEPTH, DMAX);
				default: write_reg(REG_MAX_DEPTH, $urandom_range(span));
			endcase
			load_layout(n, span);
			if (round == 3) hold_go = 1;
			nq = $urandom_range(20, 50);
			for (int j = 0; j < nq; j++) begin
				case ($urandom_range(11))
					0: push_rewrite(n);
					1: if (n < NENT) push_item(REQ_WRITE, $urandom_range(n, NENT - 1),
						$urandom, $urandom, $urandom, $urandom, $urandom);
					default: begin
						push_query(n);
						lookups++;
					end
				endcase
			end
			wait_idle();
			round++;
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("depth_dose_table_interp_lookup_unit: match");
		end else begin
			$display("depth_dose_table_interp_lookup_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#400000000;
		$display("depth_dose_table_interp_lookup_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
